// File: design/sis_pkg.sv
// Package for the sorted insertion store.
// Holds the command, queue, cell control and back-end state types used by the modules.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sis_pkg;

	localparam int KeyW = 16;
	localparam int OutCountW = 6;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_READ   = 1'b1
	} op_t;

	typedef struct packed {
		op_t             op;
		logic [KeyW-1:0] key;
	} item_t;

	typedef struct packed {
		logic            ins;
		logic            rot;
		logic [KeyW-1:0] key;
	} cell_ctl_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_READ = 1'b1
	} state_t;

endpackage

`default_nettype wire

// File: design/sis_front.sv
// Front end of the sorted insertion store: accepts command beats, classifies them
// and holds them in a two-entry queue for the back end.
// Depends on sis_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sis_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic                      command,
	input  wire logic [sis_pkg::KeyW-1:0]  value,
	output logic                           busy,
	output logic                           q_valid,
	output sis_pkg::item_t                 q_item,
	input  wire logic                      q_pop
);

	localparam int QD = 2;

	sis_pkg::item_t mem_q [QD];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     fill_q;
	logic           push;
	sis_pkg::item_t in_item;

	always_comb begin
		in_item.key = value;
		unique case (command)
			1'b1:    in_item.op = sis_pkg::OP_READ;
			default: in_item.op = sis_pkg::OP_INSERT;
		endcase
	end

	assign busy    = (fill_q == 2'(QD));
	assign push    = start && !busy;
	assign q_valid = (fill_q != 2'd0);
	assign q_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop && q_valid) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, q_pop && q_valid})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: design/sis_cells.sv
// Cell chain of the sorted insertion store: one key register per place, all
// compared at once on insert, rotated one place per cycle on read-out.
// Depends on sis_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sis_cells #(
	parameter int DEPTH = 32,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  sis_pkg::cell_ctl_t             ctl,
	output logic [CW-1:0]                  count,
	output logic                           full,
	output logic [sis_pkg::KeyW-1:0]       head
);

	logic [sis_pkg::KeyW-1:0] entry_q [DEPTH];
	logic [DEPTH-1:0]         gt;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            last_pos;

	assign count    = count_q;
	assign full     = (count_q == CW'(DEPTH));
	assign head     = entry_q[0];
	assign last_pos = count_q - CW'(1);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [sis_pkg::KeyW-1:0] shift_in;
		logic [sis_pkg::KeyW-1:0] rot_in;

		assign gt[i] = (CW'(i) < count_q) && (entry_q[i] > ctl.key);

		if (i == 0) begin : g_first
			assign shift_in = ctl.key;
		end else begin : g_rest
			assign shift_in = gt[i-1] ? entry_q[i-1] : ctl.key;
		end

		if (i == DEPTH - 1) begin : g_top
			assign rot_in = entry_q[0];
		end else begin : g_mid
			assign rot_in = (CW'(i) == last_pos) ? entry_q[0] : entry_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (ctl.ins && (gt[i] || CW'(i) == count_q)) begin
				entry_q[i] <= shift_in;
			end else if (ctl.rot && CW'(i) <= last_pos && count_q != CW'(0)) begin
				entry_q[i] <= rot_in;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.ins) begin
			count_q <= count_q + CW'(1);
		end
	end

endmodule

`default_nettype wire

// File: design/sis_back.sv
// Back end of the sorted insertion store: pops queued commands, drives the cell
// chain and registers every result beat.
// Depends on sis_pkg and the status of sis_cells.
`timescale 1ns / 1ps
`default_nettype none

module sis_back #(
	parameter int DEPTH = 32,
	parameter int CW    = $clog2(DEPTH + 1),
	parameter int IW    = $clog2(DEPTH)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          q_valid,
	input  sis_pkg::item_t                     q_item,
	output logic                               q_pop,
	output sis_pkg::cell_ctl_t                 ctl,
	input  wire logic [CW-1:0]                 count,
	input  wire logic                          full,
	input  wire logic [sis_pkg::KeyW-1:0]      head,
	output logic                               strobe,
	output logic                               is_data,
	output logic [sis_pkg::KeyW-1:0]           out_value,
	output logic                               last,
	output logic [sis_pkg::OutCountW-1:0]      entry_count,
	output logic                               rejected,
	output logic [sis_pkg::OutCountW-1:0]      order_errors
);

	sis_pkg::state_t          state_q, state_d;
	logic [IW-1:0]            idx_q;
	logic [CW-1:0]            errs_q, errs_d;
	logic [sis_pkg::KeyW-1:0] prev_q;
	logic                     read_last;
	logic                     viol;

	logic                     strobe_q, is_data_q, last_q, rejected_q;
	logic [sis_pkg::KeyW-1:0] value_q;
	logic [CW-1:0]            count_out_q;
	logic [CW-1:0]            errs_out_q;

	logic                     emit;
	logic                     emit_data, emit_last, emit_rej;
	logic [CW-1:0]            emit_count, emit_errs;
	logic [sis_pkg::KeyW-1:0] emit_value;
	logic                     start_read;

	assign read_last = (idx_q == IW'(count - CW'(1)));
	assign viol      = (idx_q != IW'(0)) && (head < prev_q);
	assign errs_d    = errs_q + CW'(viol);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sis_pkg::ST_IDLE: begin
				if (q_valid && q_item.op == sis_pkg::OP_READ && count != CW'(0)) begin
					state_d = sis_pkg::ST_READ;
				end
			end
			sis_pkg::ST_READ: begin
				if (read_last) begin
					state_d = sis_pkg::ST_IDLE;
				end
			end
			default: state_d = sis_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop      = 1'b0;
		ctl.ins    = 1'b0;
		ctl.rot    = 1'b0;
		ctl.key    = q_item.key;
		emit       = 1'b0;
		emit_data  = 1'b0;
		emit_value = '0;
		emit_last  = 1'b0;
		emit_count = count;
		emit_rej   = 1'b0;
		emit_errs  = '0;
		start_read = 1'b0;
		unique case (state_q)
			sis_pkg::ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					unique case (q_item.op)
						sis_pkg::OP_INSERT: begin
							ctl.ins    = !full;
							emit       = 1'b1;
							emit_last  = 1'b1;
							emit_rej   = full;
							emit_count = full ? count : count + CW'(1);
						end
						default: begin
							if (count == CW'(0)) begin
								emit      = 1'b1;
								emit_last = 1'b1;
							end else begin
								start_read = 1'b1;
							end
						end
					endcase
				end
			end
			sis_pkg::ST_READ: begin
				ctl.rot    = 1'b1;
				emit       = 1'b1;
				emit_data  = 1'b1;
				emit_value = head;
				emit_last  = read_last;
				emit_errs  = read_last ? errs_d : CW'(0);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sis_pkg::ST_IDLE;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (start_read) begin
			idx_q  <= '0;
			errs_q <= '0;
		end else if (state_q == sis_pkg::ST_READ) begin
			idx_q  <= idx_q + IW'(1);
			errs_q <= errs_d;
			prev_q <= head;
		end
		is_data_q   <= emit_data;
		value_q     <= emit_value;
		last_q      <= emit_last;
		count_out_q <= emit_count;
		rejected_q  <= emit_rej;
		errs_out_q  <= emit_errs;
	end

	assign strobe       = strobe_q;
	assign is_data      = is_data_q;
	assign out_value    = value_q;
	assign last         = last_q;
	assign entry_count  = sis_pkg::OutCountW'(count_out_q);
	assign rejected     = rejected_q;
	assign order_errors = sis_pkg::OutCountW'(errs_out_q);

endmodule

`default_nettype wire

// File: design/sorted_insertion_store.sv
// Top level of the sorted insertion store: front end with queue, back end and
// cell chain. Depends on sis_pkg, sis_front, sis_back and sis_cells.
//
// Usage: a command beat (command, value) is taken at a rising edge with start
// high and busy low. Command 0 inserts value at its sorted place; command 1
// reads the whole store out in ascending order. Each result beat shows on the
// result ports for exactly one cycle with strobe high, and the receiver cannot
// hold it off. An insert gives one beat (rejected high when the store is full);
// a read-out of n entries gives n data beats on consecutive cycles, the last
// carrying last, entry_count and order_errors; an empty read-out gives one beat.
// Order of events: with the back end idle, an accepted insert or empty read-out passes
// the queue and then the result registers; a read-out passes the queue and the read state first.
// Back end: an insert or an empty read-out is handled from idle as it is popped; a
// read-out of n entries is started from idle and then gives one beat per place in the
// read state as the cell chain rotates, popping no new command until its last beat.
// The two-entry queue keeps taking commands while the back end works; busy is
// high while it is full.
// Reset clears the entry count and the queue; the cell keys are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sorted_insertion_store #(
	parameter int DEPTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          command,
	input  wire logic [sis_pkg::KeyW-1:0]      value,
	output logic                               strobe,
	output logic                               is_data,
	output logic [sis_pkg::KeyW-1:0]           out_value,
	output logic                               last,
	output logic [sis_pkg::OutCountW-1:0]      entry_count,
	output logic                               rejected,
	output logic [sis_pkg::OutCountW-1:0]      order_errors
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);

	logic                     q_valid;
	logic                     q_pop;
	sis_pkg::item_t           q_item;
	sis_pkg::cell_ctl_t       ctl;
	logic [CW-1:0]            count;
	logic                     full;
	logic [sis_pkg::KeyW-1:0] head;

	sis_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.value   (value),
		.busy    (busy),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	sis_cells #(.DEPTH(DEPTH), .CW(CW)) u_cells (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.count  (count),
		.full   (full),
		.head   (head)
	);

	sis_back #(.DEPTH(DEPTH), .CW(CW), .IW(IW)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.ctl          (ctl),
		.count        (count),
		.full         (full),
		.head         (head),
		.strobe       (strobe),
		.is_data      (is_data),
		.out_value    (out_value),
		.last         (last),
		.entry_count  (entry_count),
		.rejected     (rejected),
		.order_errors (order_errors)
	);

endmodule

`default_nettype wire

// File: design/sis_checker.sv
// Port-level checker for the sorted insertion store, bound to the top level.
// Depends on sis_pkg and sorted_insertion_store.
`timescale 1ns / 1ps
`default_nettype none

module sis_port_assertions #(
	parameter int DEPTH = 32
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          strobe,
	input wire logic                          is_data,
	input wire logic [sis_pkg::KeyW-1:0]      out_value,
	input wire logic                          last,
	input wire logic [sis_pkg::OutCountW-1:0] entry_count,
	input wire logic                          rejected,
	input wire logic [sis_pkg::OutCountW-1:0] order_errors
);

	a_status_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !is_data |-> last && out_value == '0)
		else $error("Status beat is not a single final beat with zero value.");

	a_reject_full: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && rejected |-> !is_data && entry_count == sis_pkg::OutCountW'(DEPTH))
		else $error("Rejected insert does not report a full store.");

	a_errors_final: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> order_errors == '0)
		else $error("Order error count shown before the final beat.");

	a_stream: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && is_data && !last |=> strobe && is_data)
		else $error("Read-out stream broke before its final beat.");

	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && is_data && !last |=> entry_count == $past(entry_count))
		else $error("Entry count changed during a read-out.");

endmodule

bind sorted_insertion_store sis_port_assertions #(.DEPTH(DEPTH)) u_sis_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.strobe       (strobe),
	.is_data      (is_data),
	.out_value    (out_value),
	.last         (last),
	.entry_count  (entry_count),
	.rejected     (rejected),
	.order_errors (order_errors)
);

`default_nettype wire
